// ===== hw/rtl/detection_box_decode_filter_assert.svh =====
// Assertion macros shared by the detection box decode filter.
`ifndef DETECTION_BOX_DECODE_FILTER_ASSERT_SVH
`define DETECTION_BOX_DECODE_FILTER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define DBDF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define DBDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dbdf_pkg.sv =====
// Shared types, constants and helpers of the detection box decode filter.
package dbdf_pkg;

    // Field widths.
    localparam int COORD_W     = 16;
    localparam int SCORE_W     = 16;
    localparam int SCALE_W     = 16;
    localparam int PIX_W       = 12;
    localparam int IDX_W       = 3;
    localparam int MAX_CLASSES = 8;

    // Stream word layout.
    localparam int IN_W       = 4 * COORD_W + MAX_CLASSES * SCORE_W;
    localparam int SCORE_LSB  = 4 * COORD_W;
    localparam int OUT_BITS   = IDX_W + SCORE_W + 4 * PIX_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    // Size filter: each side must be over MIN_SIDE and under LIMIT_NUM/LIMIT_DEN of the frame.
    localparam int MIN_SIDE  = 10;
    localparam int LIMIT_NUM = 4;
    localparam int LIMIT_DEN = 5;

    // Configuration port.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_SCORE_THR = 3'd0;
    localparam logic [2:0] REG_SCALE_X   = 3'd1;
    localparam logic [2:0] REG_SCALE_Y   = 3'd2;
    localparam logic [2:0] REG_FRAME_W   = 3'd3;
    localparam logic [2:0] REG_FRAME_H   = 3'd4;

    localparam logic [SCORE_W-1:0] RST_SCORE_THR = 16'd19661;
    localparam logic [SCALE_W-1:0] RST_SCALE_X   = 16'd4096;
    localparam logic [SCALE_W-1:0] RST_SCALE_Y   = 16'd3072;
    localparam logic [PIX_W-1:0]   RST_FRAME_W   = 12'd640;
    localparam logic [PIX_W-1:0]   RST_FRAME_H   = 12'd480;

    // A class candidate in the argmax tree.
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [SCORE_W-1:0] score;
    } t_best;

    // One clipped axis as a lane reports it.
    typedef struct packed {
        logic [PIX_W-1:0] org;
        logic [PIX_W-1:0] size;
        logic             ok;
    } t_axis_res;

    // The higher-index candidate wins only on a strictly larger score.
    function automatic t_best pick(input t_best lo, input t_best hi);
        t_best w;
        w = (hi.score > lo.score) ? hi : lo;
        return w;
    endfunction

endpackage

// ===== hw/rtl/dbdf_axis_lane.sv =====
// One axis lane: scales an edge and a size to frame pixels, clips and size-checks them.
module dbdf_axis_lane (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [dbdf_pkg::COORD_W-1:0]  i_center,
    input  logic [dbdf_pkg::COORD_W-1:0]  i_size,
    input  logic [dbdf_pkg::SCALE_W-1:0]  i_scale,
    input  logic [dbdf_pkg::PIX_W-1:0]    i_side,
    output dbdf_pkg::t_axis_res           o_res
);

    // Stage A: edge = 2*center - size in 1/32 pixel, as sign and magnitude.
    logic [17:0] edge_diff;
    logic [16:0] edge_mag;
    logic        edge_neg;
    logic [16:0] r_a_mag;
    logic        r_a_neg;
    logic [15:0] r_a_size;

    always_comb begin
        edge_diff = {1'b0, i_center, 1'b0} - {2'b00, i_size};
        edge_neg  = edge_diff[17];
        edge_mag  = edge_neg ? 17'(~edge_diff + 18'd1) : edge_diff[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag  <= edge_mag;
            r_a_neg  <= edge_neg;
            r_a_size <= i_size;
        end
    end

    // Stage B: the two multiplications by the scale.
    logic [32:0] r_b_eprod;
    logic [31:0] r_b_sprod;
    logic        r_b_neg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_eprod <= 33'(r_a_mag) * 33'(i_scale);
            r_b_sprod <= 32'(r_a_size) * 32'(i_scale);
            r_b_neg   <= r_a_neg;
        end
    end

    // Stage C: truncate toward zero, form the far edge and clip both ends.
    logic [15:0]        edge_q;
    logic [15:0]        size_q;
    logic signed [17:0] near_edge;
    logic signed [17:0] far_edge;
    logic signed [17:0] side_s;
    logic [15:0]        r_c_org;
    logic signed [17:0] r_c_end;

    always_comb begin
        edge_q    = r_b_eprod[32:17];
        size_q    = r_b_sprod[31:16];
        near_edge = r_b_neg ? -$signed({2'b00, edge_q}) : $signed({2'b00, edge_q});
        far_edge  = near_edge + $signed({2'b00, size_q});
        side_s    = $signed({6'd0, i_side});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_org <= r_b_neg ? '0 : edge_q;
            r_c_end <= (far_edge < side_s) ? far_edge : side_s;
        end
    end

    // Clipped length and the size window, checked as 5*(len+1) <= 4*side.
    logic signed [18:0] clip_len;
    logic [12:0]        len_p1;
    logic [14:0]        len_scaled;
    logic [14:0]        side_scaled;

    always_comb begin
        clip_len    = 19'(r_c_end) - $signed({3'b000, r_c_org});
        len_p1      = {1'b0, clip_len[11:0]} + 13'd1;
        len_scaled  = 15'(len_p1) * 15'(dbdf_pkg::LIMIT_DEN);
        side_scaled = 15'(i_side) * 15'(dbdf_pkg::LIMIT_NUM);
        o_res.org   = r_c_org[11:0];
        o_res.size  = clip_len[11:0];
        o_res.ok    = (clip_len > $signed(19'(dbdf_pkg::MIN_SIDE)))
                      && (len_scaled <= side_scaled);
    end

endmodule

// ===== hw/rtl/dbdf_argmax.sv =====
// Registered three-level argmax tree over the class score lanes.
module dbdf_argmax #(
    parameter int CLASS_COUNT = 8
) (
    input  logic                                                   i_clk,
    input  logic                                                   i_en,
    input  logic [dbdf_pkg::MAX_CLASSES-1:0][dbdf_pkg::SCORE_W-1:0] i_scores,
    output dbdf_pkg::t_best                                        o_best
);

    dbdf_pkg::t_best leaf [dbdf_pkg::MAX_CLASSES];
    dbdf_pkg::t_best r_l1 [4];
    dbdf_pkg::t_best r_l2 [2];
    dbdf_pkg::t_best r_l3;

    // Leaves: classes past CLASS_COUNT score zero and can never win.
    always_comb begin
        for (int k = 0; k < dbdf_pkg::MAX_CLASSES; k++) begin
            leaf[k].idx   = dbdf_pkg::IDX_W'(k);
            leaf[k].score = (k < CLASS_COUNT) ? i_scores[k] : '0;
        end
    end

    // One tree level per pipeline stage; ties keep the lower index.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_l1[k] <= dbdf_pkg::pick(leaf[2*k], leaf[2*k+1]);
            end
            for (int k = 0; k < 2; k++) begin
                r_l2[k] <= dbdf_pkg::pick(r_l1[2*k], r_l1[2*k+1]);
            end
            r_l3 <= dbdf_pkg::pick(r_l2[0], r_l2[1]);
        end
    end

    assign o_best = r_l3;

endmodule

// ===== hw/rtl/detection_box_decode_filter.sv =====
// Top level of the detection box decode filter: config registers, lanes, merge and output skid.
// A word goes through lane stages A to C and the argmax levels, then the output register.
// Throughput: one anchor per cycle unless held, set by the three-stage lanes and argmax tree.
// A dropped anchor leaves no word; a stalled output fills the skid, then holds the pipeline.
// Reset (i_rst_n low, synchronous) clears all valids and loads the register defaults.
`include "detection_box_decode_filter_assert.svh"

module detection_box_decode_filter #(
    parameter int CLASS_COUNT = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Anchor words in.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // center_x, center_y, box_w, box_h, score0 .. score7, 16 bits each
    input  logic [dbdf_pkg::IN_W-1:0]     s_axis_tdata,
    // Detection words out.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // class_index, best_score, left_px, top_px, width_px, height_px, zero pad
    output logic [dbdf_pkg::OUT_W-1:0]    m_axis_tdata,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dbdf_pkg::APB_AW-1:0]   paddr,
    input  logic [dbdf_pkg::APB_DW-1:0]   pwdata,
    output logic [dbdf_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    // Configuration registers.
    logic [dbdf_pkg::SCORE_W-1:0] r_thr;
    logic [dbdf_pkg::SCALE_W-1:0] r_scale_x;
    logic [dbdf_pkg::SCALE_W-1:0] r_scale_y;
    logic [dbdf_pkg::PIX_W-1:0]   r_frame_w;
    logic [dbdf_pkg::PIX_W-1:0]   r_frame_h;
    logic [2:0]                   reg_sel;
    logic                         cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = paddr[dbdf_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= dbdf_pkg::RST_SCORE_THR;
            r_scale_x <= dbdf_pkg::RST_SCALE_X;
            r_scale_y <= dbdf_pkg::RST_SCALE_Y;
            r_frame_w <= dbdf_pkg::RST_FRAME_W;
            r_frame_h <= dbdf_pkg::RST_FRAME_H;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                dbdf_pkg::REG_SCORE_THR: r_thr     <= pwdata[dbdf_pkg::SCORE_W-1:0];
                dbdf_pkg::REG_SCALE_X:   r_scale_x <= pwdata[dbdf_pkg::SCALE_W-1:0];
                dbdf_pkg::REG_SCALE_Y:   r_scale_y <= pwdata[dbdf_pkg::SCALE_W-1:0];
                dbdf_pkg::REG_FRAME_W:   r_frame_w <= pwdata[dbdf_pkg::PIX_W-1:0];
                dbdf_pkg::REG_FRAME_H:   r_frame_h <= pwdata[dbdf_pkg::PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (reg_sel)
            dbdf_pkg::REG_SCORE_THR: prdata = dbdf_pkg::APB_DW'(r_thr);
            dbdf_pkg::REG_SCALE_X:   prdata = dbdf_pkg::APB_DW'(r_scale_x);
            dbdf_pkg::REG_SCALE_Y:   prdata = dbdf_pkg::APB_DW'(r_scale_y);
            dbdf_pkg::REG_FRAME_W:   prdata = dbdf_pkg::APB_DW'(r_frame_w);
            dbdf_pkg::REG_FRAME_H:   prdata = dbdf_pkg::APB_DW'(r_frame_h);
            default:                 prdata = '0;
        endcase
    end

    // Pipeline advance: the whole pipeline moves while the skid stage is empty.
    logic       pipe_en;
    logic [2:0] r_vld;
    logic       r_skid_vld;
    logic       r_out_vld;

    assign pipe_en       = !r_skid_vld;
    assign s_axis_tready = pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[1:0], s_axis_tvalid};
        end
    end

    // Unpack the score lanes.
    logic [dbdf_pkg::MAX_CLASSES-1:0][dbdf_pkg::SCORE_W-1:0] scores;

    always_comb begin
        for (int k = 0; k < dbdf_pkg::MAX_CLASSES; k++) begin
            scores[k] = s_axis_tdata[dbdf_pkg::SCORE_LSB + k*dbdf_pkg::SCORE_W +: dbdf_pkg::SCORE_W];
        end
    end

    dbdf_pkg::t_best     best;
    dbdf_pkg::t_axis_res res_x;
    dbdf_pkg::t_axis_res res_y;

    dbdf_argmax #(
        .CLASS_COUNT (CLASS_COUNT)
    ) u_argmax (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_scores (scores),
        .o_best   (best)
    );

    dbdf_axis_lane u_lane_x (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_center (s_axis_tdata[15:0]),
        .i_size   (s_axis_tdata[47:32]),
        .i_scale  (r_scale_x),
        .i_side   (r_frame_w),
        .o_res    (res_x)
    );

    dbdf_axis_lane u_lane_y (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_center (s_axis_tdata[31:16]),
        .i_size   (s_axis_tdata[63:48]),
        .i_scale  (r_scale_y),
        .i_side   (r_frame_h),
        .o_res    (res_y)
    );

    // Merge: the anchor passes only if the score and both axes pass.
    logic                        pass;
    logic [dbdf_pkg::OUT_W-1:0]  res_word;

    always_comb begin
        pass     = r_vld[2] && (best.score >= r_thr) && res_x.ok && res_y.ok;
        res_word = dbdf_pkg::OUT_W'({res_y.size, res_x.size, res_y.org, res_x.org,
                                     best.score, best.idx});
    end

    // Output register with a skid stage behind it.
    logic [dbdf_pkg::OUT_W-1:0] r_out_data;
    logic [dbdf_pkg::OUT_W-1:0] r_skid_data;
    logic [dbdf_pkg::OUT_W-1:0] n_out_data;
    logic [dbdf_pkg::OUT_W-1:0] n_skid_data;
    logic                       n_out_vld;
    logic                       n_skid_vld;

    always_comb begin
        n_out_data  = r_out_data;
        n_skid_data = r_skid_data;
        n_out_vld   = r_out_vld;
        n_skid_vld  = r_skid_vld;
        if (r_out_vld && m_axis_tready) begin
            n_out_vld  = r_skid_vld;
            n_out_data = r_skid_data;
            n_skid_vld = 1'b0;
        end
        if (pipe_en && pass) begin
            if (!n_out_vld) begin
                n_out_vld  = 1'b1;
                n_out_data = res_word;
            end else begin
                n_skid_vld  = 1'b1;
                n_skid_data = res_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // Checks on the filter and the output staging.
    `DBDF_ASSERT_NOW(a_min_side, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[54:43] > 12'(dbdf_pkg::MIN_SIDE)) && (m_axis_tdata[66:55] > 12'(dbdf_pkg::MIN_SIDE)), "box side at or below minimum")
    `DBDF_ASSERT_NOW(a_score_thr, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[18:3] >= r_thr, "result score under threshold")
    `DBDF_ASSERT_NOW(a_class_rng, i_clk, i_rst_n, m_axis_tvalid, 32'(m_axis_tdata[2:0]) < CLASS_COUNT, "class index out of range")
    `DBDF_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, r_skid_vld, r_out_vld, "skid word lost")

endmodule

// ===== dv/detection_box_decode_filter_checker.sv =====
// Checker for the detection box decode filter: predicts detections and compares output words.
`timescale 1ns / 1ps

module detection_box_decode_filter_checker #(
    parameter int CLASSES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [dbdf_pkg::IN_W-1:0]     i_s_tdata,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [dbdf_pkg::OUT_W-1:0]    i_m_tdata,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [dbdf_pkg::APB_AW-1:0]   i_paddr,
    input  logic [dbdf_pkg::APB_DW-1:0]   i_pwdata,
    input  logic                          i_pready,
    output int                            o_pending,
    output int                            o_fail_count
);
    import dbdf_pkg::*;

    localparam int PRINT_CAP = 40;

    // One detection word; the first member sits in the highest bits.
    typedef struct packed {
        logic [PIX_W-1:0]   height;
        logic [PIX_W-1:0]   width;
        logic [PIX_W-1:0]   top;
        logic [PIX_W-1:0]   left;
        logic [SCORE_W-1:0] score;
        logic [IDX_W-1:0]   cls;
    } t_detection;

    // Our own copy of the filter settings, tracked from the configuration bus.
    logic [SCORE_W-1:0] min_score;
    logic [SCALE_W-1:0] x_scale;
    logic [SCALE_W-1:0] y_scale;
    logic [PIX_W-1:0]   frame_w;
    logic [PIX_W-1:0]   frame_h;

    t_detection detection_q[$];
    t_detection want;
    t_detection got;
    int         fails = 0;
    int         words_seen = 0;

    // Prints one line per mismatch, for the first PRINT_CAP of them, and counts every one.
    task automatic report_mismatch(input string msg);
        if (fails < PRINT_CAP)
            $display("[%0t] ERROR: %s", $realtime, msg);
        fails++;
    endtask

    task automatic compare_field(input string name, input int seen, input int wanted);
        if (seen != wanted)
            report_mismatch($sformatf("word %0d: %s is %0d, expected %0d",
                                      words_seen, name, seen, wanted));
    endtask

    // Edge in 1/32 pixel times a Q4.12 scale, truncated toward zero to whole pixels.
    function automatic longint scale_edge(input longint e, input longint scale);
        longint mag;
        longint q;
        mag = (e < 0) ? -e : e;
        q = (mag * scale) >>> 17;
        return (e < 0) ? -q : q;
    endfunction

    // Clips [start, start + len) to [0, side).
    function automatic void clip_span(input longint start, input longint len, input longint side,
                                      output longint org, output longint span);
        longint stop;
        org = (start < 0) ? 0 : start;
        stop = start + len;
        if (stop > side)
            stop = side;
        span = stop - org;
    endfunction

    // Decodes one anchor under the current settings; returns 1 when it survives the filters.
    function automatic bit decode_anchor(input logic [IN_W-1:0] word, output t_detection det);
        logic [SCORE_W-1:0] best;
        logic [SCORE_W-1:0] s;
        logic [IDX_W-1:0]   cls;
        longint cx, cy, bw, bh, left, top, w, h, x0, y0, cw, ch, max_w, max_h;
        best = '0;
        cls = '0;
        det = '0;
        for (int c = 0; c < CLASSES; c++) begin
            s = word[SCORE_LSB + SCORE_W * c +: SCORE_W];
            if (s > best) begin
                best = s;
                cls = c[IDX_W-1:0];
            end
        end
        if (best < min_score)
            return 1'b0;

        cx = longint'(word[0 +: COORD_W]);
        cy = longint'(word[COORD_W +: COORD_W]);
        bw = longint'(word[2 * COORD_W +: COORD_W]);
        bh = longint'(word[3 * COORD_W +: COORD_W]);
        left = scale_edge(2 * cx - bw, longint'(x_scale));
        top = scale_edge(2 * cy - bh, longint'(y_scale));
        w = (bw * longint'(x_scale)) >>> 16;
        h = (bh * longint'(y_scale)) >>> 16;
        clip_span(left, w, longint'(frame_w), x0, cw);
        clip_span(top, h, longint'(frame_h), y0, ch);
        if (cw <= 0 || ch <= 0)
            return 1'b0;

        max_w = (longint'(frame_w) * LIMIT_NUM) / LIMIT_DEN;
        max_h = (longint'(frame_h) * LIMIT_NUM) / LIMIT_DEN;
        if (!(cw > MIN_SIDE && ch > MIN_SIDE && cw < max_w && ch < max_h))
            return 1'b0;

        det.cls = cls;
        det.score = best;
        det.left = x0[PIX_W-1:0];
        det.top = y0[PIX_W-1:0];
        det.width = cw[PIX_W-1:0];
        det.height = ch[PIX_W-1:0];
        return 1'b1;
    endfunction

    // Watch all three channels at each edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            min_score = RST_SCORE_THR;
            x_scale = RST_SCALE_X;
            y_scale = RST_SCALE_Y;
            frame_w = RST_FRAME_W;
            frame_h = RST_FRAME_H;
            detection_q.delete();
        end else begin
            // Outgoing detection words against the oldest prediction.
            if (i_m_tvalid && i_m_tready) begin
                got = t_detection'(i_m_tdata[OUT_BITS-1:0]);
                if (detection_q.size() == 0) begin
                    report_mismatch($sformatf("word %0d arrived with no detection expected",
                                              words_seen));
                end else begin
                    want = detection_q.pop_front();
                    compare_field("class_index", int'(got.cls), int'(want.cls));
                    compare_field("best_score", int'(got.score), int'(want.score));
                    compare_field("left_px", int'(got.left), int'(want.left));
                    compare_field("top_px", int'(got.top), int'(want.top));
                    compare_field("width_px", int'(got.width), int'(want.width));
                    compare_field("height_px", int'(got.height), int'(want.height));
                end
                words_seen++;
            end

            // Incoming anchors.
            if (i_s_tvalid && i_s_tready) begin
                if (decode_anchor(i_s_tdata, want))
                    detection_q = {detection_q, want};
            end

            // Register writes; unknown indexes are ignored.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_SCORE_THR: min_score = i_pwdata[SCORE_W-1:0];
                    REG_SCALE_X:   x_scale = i_pwdata[SCALE_W-1:0];
                    REG_SCALE_Y:   y_scale = i_pwdata[SCALE_W-1:0];
                    REG_FRAME_W:   frame_w = i_pwdata[PIX_W-1:0];
                    REG_FRAME_H:   frame_h = i_pwdata[PIX_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= detection_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== dv/tb_detection_box_decode_filter.sv =====
// Testbench top for the detection box decode filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_detection_box_decode_filter;
    import dbdf_pkg::*;

    localparam int CLASSES     = 8;
    localparam int STALL_LIMIT = 5000;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int pending;
    int fail_count;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int quiet_cycles = 0;

    // Settings last written, used to shape the anchors.
    logic [SCORE_W-1:0] cur_thr = RST_SCORE_THR;
    logic [SCALE_W-1:0] cur_sx = RST_SCALE_X;
    logic [SCALE_W-1:0] cur_sy = RST_SCALE_Y;
    logic [PIX_W-1:0]   cur_fw = RST_FRAME_W;
    logic [PIX_W-1:0]   cur_fh = RST_FRAME_H;

    detection_box_decode_filter #(
        .CLASS_COUNT(CLASSES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    detection_box_decode_filter_checker #(
        .CLASSES(CLASSES)
    ) checker_i (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid),
        .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata),
        .i_m_tvalid(m_axis_tvalid),
        .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata),
        .i_psel(psel),
        .i_penable(penable),
        .i_pwrite(pwrite),
        .i_paddr(paddr),
        .i_pwdata(pwdata),
        .i_pready(pready),
        .o_pending(pending),
        .o_fail_count(fail_count)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: stalls at random at the rate of the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog: ends the run when no word or register access moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [IN_W-1:0] anchor_word(input logic [COORD_W-1:0] cx,
                                                    input logic [COORD_W-1:0] cy,
                                                    input logic [COORD_W-1:0] bw,
                                                    input logic [COORD_W-1:0] bh,
                                                    input logic [CLASSES*SCORE_W-1:0] scores);
        return {scores, bh, bw, cy, cx};
    endfunction

    // Picks centre and size on one axis so the scaled box mostly lands inside the size window.
    function automatic void shape_axis(input longint scale, input longint side,
                                       output logic [COORD_W-1:0] centre,
                                       output logic [COORD_W-1:0] span);
        longint target;
        longint net;
        longint origin;
        longint doubled;
        if (scale == 0 || side < 2) begin
            centre = COORD_W'($urandom());
            span = COORD_W'($urandom());
            return;
        end
        target = longint'($urandom_range(int'(side * LIMIT_NUM / LIMIT_DEN + 2), MIN_SIDE));
        net = (target * 65536 + scale - 1) / scale;
        if (net > 65535)
            net = 65535;
        origin = longint'($urandom_range(int'(side))) - target / 2;
        doubled = (origin * 131072) / scale + net;
        if (doubled < 0)
            doubled = 0;
        if (doubled > 131071)
            doubled = 131071;
        centre = doubled[16:1];
        span = net[COORD_W-1:0];
    endfunction

    // Mostly plausible anchors with a winning class at or over the threshold; the rest is noise.
    function automatic logic [IN_W-1:0] random_anchor();
        logic [IN_W-1:0]    word;
        logic [COORD_W-1:0] cx, cy, bw, bh;
        logic [SCORE_W-1:0] top_score;
        int                 winner;
        for (int k = 0; k < IN_W / 32; k++)
            word[k * 32 +: 32] = $urandom();
        if ($urandom_range(99) < 30)
            return word;
        shape_axis(longint'(cur_sx), longint'(cur_fw), cx, bw);
        shape_axis(longint'(cur_sy), longint'(cur_fh), cy, bh);
        word[4 * COORD_W - 1:0] = {bh, bw, cy, cx};
        for (int c = 0; c < CLASSES; c++)
            word[SCORE_LSB + SCORE_W * c +: SCORE_W] = SCORE_W'($urandom_range(int'(cur_thr)));
        winner = $urandom_range(CLASSES - 1);
        top_score = SCORE_W'($urandom_range(65535, int'(cur_thr)));
        word[SCORE_LSB + SCORE_W * winner +: SCORE_W] = top_score;
        // Now and then a second class ties with the winner.
        if ($urandom_range(9) == 0)
            word[SCORE_LSB + SCORE_W * $urandom_range(CLASSES - 1) +: SCORE_W] = top_score;
        return word;
    endfunction

    // Offers one anchor word, after a random gap, and returns at the edge that takes it.
    task automatic push_anchor(input logic [IN_W-1:0] word);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // One register write: setup phase, access phase until pready, then idle.
    task automatic write_reg(input logic [2:0] index, input logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stops sending and waits until every expected detection is out and the pipe is empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_filter(input logic [SCORE_W-1:0] thr, input logic [SCALE_W-1:0] sx,
                              input logic [SCALE_W-1:0] sy, input logic [PIX_W-1:0] fw,
                              input logic [PIX_W-1:0] fh);
        settle();
        write_reg(REG_SCORE_THR, APB_DW'(thr));
        write_reg(REG_SCALE_X, APB_DW'(sx));
        write_reg(REG_SCALE_Y, APB_DW'(sy));
        write_reg(REG_FRAME_W, APB_DW'(fw));
        write_reg(REG_FRAME_H, APB_DW'(fh));
        cur_thr = thr;
        cur_sx = sx;
        cur_sy = sy;
        cur_fw = fw;
        cur_fh = fh;
    endtask

    task automatic run_phase(input logic [SCORE_W-1:0] thr, input logic [SCALE_W-1:0] sx,
                             input logic [SCALE_W-1:0] sy, input logic [PIX_W-1:0] fw,
                             input logic [PIX_W-1:0] fh, input int src_pct, input int sink_pct,
                             input int count);
        set_filter(thr, sx, sy, fw, fh);
        src_idle_pct = src_pct;
        sink_stall_pct <= sink_pct;
        repeat (count)
            push_anchor(random_anchor());
    endtask

    // Main sequence.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed anchors under the reset settings (640x480 frame, threshold 0.3).
        push_anchor(anchor_word(5120, 3840, 1600, 1600, '0));
        push_anchor(anchor_word(5120, 3840, 1600, 1600, {8{16'd40000}}));
        push_anchor(anchor_word(5120, 3840, 1600, 1600, {16'd50000, {7{16'd40000}}}));
        push_anchor(anchor_word(5120, 3840, 1600, 1600, {{7{16'd0}}, RST_SCORE_THR}));
        push_anchor(anchor_word(5120, 3840, 1600, 1600,
                                {{4{16'd0}}, RST_SCORE_THR - 16'd1, {3{16'd0}}}));
        push_anchor({IN_W{1'b1}});
        push_anchor('0);
        // Box hanging over the left and the right frame edges.
        push_anchor(anchor_word(0, 3840, 1600, 1600, {8{16'hFFFF}}));
        push_anchor(anchor_word(10240, 3840, 1600, 1600, {8{16'hFFFF}}));
        // Width just at and just over the minimum side.
        push_anchor(anchor_word(5120, 3840, 160, 1600, {16'd0, {7{16'd30000}}}));
        push_anchor(anchor_word(5120, 3840, 176, 1600, {16'd0, {7{16'd30000}}}));
        // Width and height at and just under 80% of the frame.
        push_anchor(anchor_word(5120, 3840, 8192, 1600, {8{16'd20000}}));
        push_anchor(anchor_word(5120, 3840, 8176, 1600, {8{16'd20000}}));
        push_anchor(anchor_word(5120, 6000, 1600, 8192, {8{16'd20000}}));
        push_anchor(anchor_word(5120, 6000, 1600, 8171, {8{16'd20000}}));

        // Zero threshold: an anchor with all scores zero gets through as class 0.
        set_filter('0, 16'd4096, 16'd4096, 12'd4095, 12'd4095);
        for (int r = REG_FRAME_H + 1; r < 8; r++)
            write_reg(r[2:0], $urandom());
        push_anchor(anchor_word(16000, 16000, 1600, 1600, '0));
        push_anchor(anchor_word(16000, 16000, 1600, 1600, {8{16'd7}}));
        // Zero scale empties the box.
        set_filter('0, '0, 16'd4096, 12'd4095, 12'd4095);
        push_anchor(anchor_word(16000, 16000, 1600, 1600, {8{16'hFFFF}}));
        push_anchor(random_anchor());
        // Zero frame side leaves no room at all.
        set_filter('0, 16'd4096, 16'd4096, '0, '0);
        push_anchor(anchor_word(16000, 16000, 1600, 1600, {8{16'hFFFF}}));
        push_anchor(random_anchor());

        // Random phases across settings and idling patterns.
        run_phase(RST_SCORE_THR, RST_SCALE_X, RST_SCALE_Y, RST_FRAME_W, RST_FRAME_H, 0, 0, 200);
        run_phase(16'd1, 16'hFFFF, 16'hFFFF, 12'd4095, 12'd4095, 64, 0, 200);
        run_phase(16'hFFFF, 16'd2048, 16'd8192, 12'd1920, 12'd1080, 0, 64, 200);
        run_phase(16'hFFFF, 16'd1, 16'd1, 12'd1, 12'd1, 14, 14, 60);
        run_phase(SCORE_W'($urandom_range(65535, 1)), SCALE_W'($urandom_range(65535, 1)),
                  SCALE_W'($urandom_range(65535, 1)), PIX_W'($urandom_range(4095, 32)),
                  PIX_W'($urandom_range(4095, 32)), 14, 14, 200);
        run_phase(SCORE_W'($urandom_range(65535, 1)), SCALE_W'($urandom_range(16384, 1024)),
                  SCALE_W'($urandom_range(16384, 1024)), PIX_W'($urandom_range(4095, 32)),
                  PIX_W'($urandom_range(4095, 32)), 0, 0, 200);
        run_phase(SCORE_W'($urandom_range(65535, 1)), SCALE_W'($urandom_range(65535, 1)),
                  SCALE_W'($urandom_range(65535, 1)), PIX_W'($urandom_range(4095, 32)),
                  PIX_W'($urandom_range(4095, 32)), 64, 0, 200);
        run_phase(SCORE_W'($urandom_range(65535, 1)), SCALE_W'($urandom_range(16384, 1024)),
                  SCALE_W'($urandom_range(16384, 1024)), PIX_W'($urandom_range(4095, 32)),
                  PIX_W'($urandom_range(4095, 32)), 0, 64, 200);
        run_phase(SCORE_W'($urandom_range(32768, 1)), SCALE_W'($urandom_range(16384, 1024)),
                  SCALE_W'($urandom_range(16384, 1024)), PIX_W'($urandom_range(4095, 32)),
                  PIX_W'($urandom_range(4095, 32)), 14, 14, 200);

        settle();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dbdf_pkg.sv
hw/rtl/dbdf_axis_lane.sv
hw/rtl/dbdf_argmax.sv
hw/rtl/detection_box_decode_filter.sv
dv/detection_box_decode_filter_checker.sv
dv/tb_detection_box_decode_filter.sv
